@@ hw/rtl/dcso_pkg.sv @@
// Shared types and constants for the distributed-clock sync offset block
`timescale 1ns / 1ps
`default_nettype none
package dcso_pkg;

  localparam int CYCLE_W     = 30;
  localparam int REM_W       = 30;
  localparam int OFFSET_W    = 28;
  localparam int ERROR_W     = 30;
  localparam int ERR_DIV     = 100;
  localparam int INT_DIV     = 20;
  localparam int CYCLE_RESET = 1000000;
  localparam int OFF_MAX     = 134217727;
  localparam int OFF_MIN     = -134217728;
  localparam logic [2:0] ADDR_CYCLE_TIME = 3'd0;

  // floor(x / 100) == (x * ERR_RECIP) >> ERR_SHIFT for every 32-bit unsigned x
  localparam logic [31:0] ERR_RECIP = 32'h51EB_851F;
  localparam int          ERR_SHIFT = 37;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_TIME,
    ST_WRAP,
    ST_LD_ERR,
    ST_FINISH
  } dcso_state_t;

  typedef struct packed {
    logic load_time;
    logic step;
    logic wrap;
    logic load_err;
    logic emit;
  } dcso_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } dcso_sts_t;

endpackage
`default_nettype wire

@@ hw/rtl/dcso_ctrl.sv @@
// Sequencer for the sync offset block: steps through remainder, wrap, scale and emit phases
`timescale 1ns / 1ps
`default_nettype none
module dcso_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  dcso_pkg::dcso_sts_t   sts_i,
  output dcso_pkg::dcso_cmd_t   cmd_o
);
  import dcso_pkg::*;

  dcso_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_tvalid) state_nxt = ST_DIV_TIME;
      ST_DIV_TIME: if (sts_i.div_done) state_nxt = ST_WRAP;
      ST_WRAP:     state_nxt = ST_LD_ERR;
      ST_LD_ERR:   state_nxt = ST_FINISH;
      ST_FINISH:   if (sts_i.out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready       = 1'b1;
        cmd_o.load_time = in_tvalid;
      end
      ST_DIV_TIME: cmd_o.step     = !sts_i.div_done;
      ST_WRAP:     cmd_o.wrap     = 1'b1;
      ST_LD_ERR:   cmd_o.load_err = 1'b1;
      ST_FINISH:   cmd_o.emit     = sts_i.out_free;
      default: begin
        cmd_o     = '0;
        in_tready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/dcso_datapath.sv @@
// Datapath: restoring remainder, phase wrap, integral counter, offset scale, output register
`timescale 1ns / 1ps
`default_nettype none
module dcso_datapath #(
  parameter int TIME_WIDTH     = 64,
  parameter int INTEGRAL_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [TIME_WIDTH-2:0] ref_time_i,
  input  wire logic [dcso_pkg::CYCLE_W-1:0] cycle_time_i,
  input  dcso_pkg::dcso_cmd_t        cmd_i,
  output dcso_pkg::dcso_sts_t        sts_o,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [63:0]                out_tdata
);
  import dcso_pkg::*;

  localparam int IW = INTEGRAL_WIDTH;
  localparam int DW = TIME_WIDTH - 1;
  localparam int CW = $clog2(DW + 1);
  localparam int SW = ((IW > ERROR_W) ? IW : ERROR_W) + 2;
  localparam int PW = ERROR_W + 32;
  localparam int RW = $clog2(INT_DIV);
  localparam logic signed [IW-1:0] I_MAX  = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] I_MIN  = {1'b1, {(IW-1){1'b0}}};
  localparam logic [RW-1:0]        IR_TOP = RW'(INT_DIV - 1);

  logic [DW-1:0]      dvd_r, dvd_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic signed [ERROR_W-1:0] err_r, err_nxt;
  logic signed [IW-1:0] integ_r, integ_nxt;
  logic [IW-1:0]      iq_r, iq_nxt;
  logic [RW-1:0]      ir_r, ir_nxt;
  logic [ERROR_W-1:0] qe_r;
  logic               out_valid_r;
  logic [OFFSET_W-1:0] out_off_r;
  logic [ERROR_W-1:0] out_err_r;

  logic [REM_W:0]     rem_sh;
  logic [REM_W:0]     rem_diff;
  logic               ge;
  logic               cyc_zero;
  logic               over_half;
  logic               err_pos;
  logic               err_neg;
  logic [REM_W:0]     wrap_diff;
  logic               integ_up;
  logic               integ_dn;
  logic               integ_neg;
  logic               integ_zero;
  logic               mag_up;
  logic               mag_dn;
  logic [ERROR_W-1:0] emag;
  logic [PW-1:0]      eprod;
  logic [SW-1:0]      term_e;
  logic [SW-1:0]      term_i;
  logic signed [SW-1:0] off_sum;
  logic [OFFSET_W-1:0] off_sat;

  // One remainder bit per cycle against the cycle time
  assign rem_sh   = {rem_r, dvd_r[DW-1]};
  assign rem_diff = rem_sh - {1'b0, cycle_time_i};
  assign ge       = rem_sh >= {1'b0, cycle_time_i};

  // Phase wrap into (-cycle/2, cycle/2]
  assign cyc_zero  = (cycle_time_i == '0);
  assign over_half = rem_r > (cycle_time_i >> 1);
  assign wrap_diff = {1'b0, rem_r} - {1'b0, cycle_time_i};
  assign err_pos   = !cyc_zero && !over_half && (rem_r != '0);
  assign err_neg   = !cyc_zero && over_half;

  // Integral step, and the matching step of its magnitude
  assign integ_neg  = integ_r[IW-1];
  assign integ_zero = (integ_r == '0);
  assign integ_up   = err_pos && integ_r != I_MAX;
  assign integ_dn   = err_neg && integ_r != I_MIN;
  assign mag_up     = integ_up ? !integ_neg : (integ_dn && (integ_neg || integ_zero));
  assign mag_dn     = integ_up ? integ_neg : (integ_dn && !integ_neg && !integ_zero);

  // |err| / 100 by reciprocal multiplication
  assign emag  = err_r[ERROR_W-1] ? ERROR_W'(-err_r) : err_r;
  assign eprod = PW'(emag) * PW'(ERR_RECIP);

  // offset = -(err/100) - (integral/20), quotients held as magnitudes
  assign term_e  = err_r[ERROR_W-1] ? SW'(qe_r) : SW'(-SW'(qe_r));
  assign term_i  = integ_neg ? SW'(iq_r) : SW'(-SW'(iq_r));
  assign off_sum = $signed(term_e + term_i);

  always_comb begin
    if (off_sum > $signed(SW'(OFF_MAX))) begin
      off_sat = OFFSET_W'(OFF_MAX);
    end else if (off_sum < $signed(SW'(OFF_MIN))) begin
      off_sat = OFFSET_W'(OFF_MIN);
    end else begin
      off_sat = off_sum[OFFSET_W-1:0];
    end
  end

  always_comb begin
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    integ_nxt = integ_r;
    iq_nxt    = iq_r;
    ir_nxt    = ir_r;
    priority if (cmd_i.load_time) begin
      dvd_nxt = ref_time_i;
      rem_nxt = '0;
      cnt_nxt = CW'(DW);
    end else if (cmd_i.step) begin
      dvd_nxt = {dvd_r[DW-2:0], ge};
      rem_nxt = ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
    end else if (cmd_i.wrap) begin
      if (cyc_zero) begin
        err_nxt = '0;
      end else if (over_half) begin
        err_nxt = $signed(wrap_diff[ERROR_W-1:0]);
      end else begin
        err_nxt = $signed(rem_r[ERROR_W-1:0]);
      end
      if (integ_up) begin
        integ_nxt = integ_r + IW'(1);
      end else if (integ_dn) begin
        integ_nxt = integ_r - IW'(1);
      end
      // Keep |integral| as quotient and remainder by 20
      if (mag_up) begin
        if (ir_r == IR_TOP) begin
          ir_nxt = '0;
          iq_nxt = iq_r + IW'(1);
        end else begin
          ir_nxt = ir_r + RW'(1);
        end
      end else if (mag_dn) begin
        if (ir_r == '0) begin
          ir_nxt = IR_TOP;
          iq_nxt = iq_r - IW'(1);
        end else begin
          ir_nxt = ir_r - RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      integ_r     <= '0;
      iq_r        <= '0;
      ir_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      integ_r <= integ_nxt;
      iq_r    <= iq_nxt;
      ir_r    <= ir_nxt;
      if (cmd_i.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    err_r <= err_nxt;
    if (cmd_i.load_err) begin
      qe_r <= ERROR_W'(eprod >> ERR_SHIFT);
    end
    if (cmd_i.emit) begin
      out_off_r <= off_sat;
      out_err_r <= err_r;
    end
  end

  assign sts_o.div_done = (cnt_r == '0);
  assign sts_o.out_free = !out_valid_r || out_tready;
  assign out_tvalid     = out_valid_r;
  assign out_tdata      = {{(64-OFFSET_W-ERROR_W){1'b0}}, out_err_r, out_off_r};

  a_step_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.step |-> cnt_r != '0)
    else $error("divider stepped past its last bit");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.emit |-> !out_valid_r || out_tready)
    else $error("result overwrote an untaken beat");

  a_zero_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.wrap && cyc_zero |=> err_r == '0 && $stable(integ_r))
    else $error("zero cycle time produced a phase error");

  a_integ_unit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.wrap |=> (integ_r == $past(integ_r)) ||
                   (integ_r == $past(integ_r) + IW'(1)) ||
                   (integ_r == $past(integ_r) - IW'(1)))
    else $error("integral moved by more than one");

  a_integ_rem: assert property (@(posedge clk) disable iff (!rst_n)
    ir_r <= IR_TOP)
    else $error("integral remainder left its range");

endmodule
`default_nettype wire

@@ hw/rtl/dc_cycle_sync_offset_unit.sv @@
// Top level of the distributed-clock cycle sync offset PI loop
// An input beat runs through the sequencer phases before out_tvalid rises:
//   the one-bit-per-cycle restoring remainder over TIME_WIDTH-1 bits,
//   then the wrap, the error/100 reciprocal multiply and the output load.
// A new beat is taken only once the last result is loaded into the output register;
//   a held result keeps the next beat off until out_tready returns.
// Reset (synchronous, rst_n low): cycle_time to 1000000, integral to zero, no result held.
`timescale 1ns / 1ps
`default_nettype none
module dc_cycle_sync_offset_unit #(
  parameter int TIME_WIDTH     = 64,
  parameter int INTEGRAL_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream: [62:0] ref_time
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,
  // result stream: [27:0] offset_time, [57:28] phase_error
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,
  // configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import dcso_pkg::*;

  logic [CYCLE_W-1:0] cycle_time_r;
  logic               cfg_wr;
  dcso_cmd_t          cmd;
  dcso_sts_t          sts;

  // Register decode: only index 0 (cycle_time) exists, anything else is dropped
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == ADDR_CYCLE_TIME);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_time_r <= CYCLE_W'(CYCLE_RESET);
    end else if (cfg_wr) begin
      cycle_time_r <= cfg_pwdata[CYCLE_W-1:0];
    end
  end

  // Read back the cycle time; unmapped addresses read as zero
  assign cfg_prdata = (cfg_paddr == ADDR_CYCLE_TIME) ? 32'(cycle_time_r) : '0;

  // Sequencer: accept a beat only when idle, then walk the divide, wrap, scale and emit phases
  dcso_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // Datapath: only the low TIME_WIDTH-1 bits of the reference time take part
  dcso_datapath #(
    .TIME_WIDTH     (TIME_WIDTH),
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .ref_time_i   (in_tdata[TIME_WIDTH-2:0]),
    .cycle_time_i (cycle_time_r),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata)
  );

endmodule
`default_nettype wire
